/* hw/rtl/gopd_pkg.sv */
// Shared types and constants for the glyph outline point decoder.
// No dependencies; imported by the decoder top level and its testbench.
package gopd_pkg;

	// Largest point count a glyph may have; stores are this deep
	localparam int MAX_POINTS = 64;
	localparam int PT_AW      = 6;

	// Flag bits of a simple glyph
	localparam int FLAG_X_SHORT = 1;
	localparam int FLAG_Y_SHORT = 2;
	localparam int FLAG_REPEAT  = 3;
	localparam int FLAG_X_SAME  = 4;
	localparam int FLAG_Y_SAME  = 5;

	localparam logic [15:0] BBOX_BYTES = 16'd8;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_COMPOSITE = 2'd1,
		ST_TOO_MANY  = 2'd2
	} status_t;

	// Record parse phase
	typedef enum logic [3:0] {
		PH_IDLE, PH_NC_LO, PH_BBOX, PH_ENDPTS, PH_ILEN_HI, PH_ILEN_LO,
		PH_INSTR, PH_FLAG, PH_REPEAT, PH_XB, PH_XL, PH_YB, PH_YL, PH_DONE
	} phase_t;

	// Sequencer state
	typedef enum logic [2:0] {
		C_IN, C_RPT, C_XRD, C_XEV, C_YRD, C_YEV, C_PEMIT, C_ERR
	} ctl_t;

endpackage

/* hw/rtl/gopd_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
// Generic; no package dependency.
module gopd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

/* hw/rtl/glyph_outline_point_decoder_unit.sv */
// Glyph outline point decoder, top level.
// Uses gopd_pkg and two gopd_ram instances (flag store, x store).

// Takes a simple-glyph record one byte per transfer (tuser marks the first
// byte) and returns one transfer per point with absolute x and y, or one
// status transfer for a composite or oversized glyph. Header, end-point,
// instruction and coordinate bytes are taken one per cycle while s_tready is
// high. Flag repeats fill the flag store at one point per cycle with input
// stalled; the x and y passes read the flag store through its registered
// port, so every point passes a read and an evaluate state before its
// coordinate bytes are taken, a point with y bytes loads its result after
// them, and points with no y bytes are sent with no input taken. A result
// waits in the output register while the next lookup runs; the block stalls
// only when a second result is ready before the first has been taken.
module glyph_outline_point_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] first_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [15:0] x_coord, [31:16] y_coord, [37:32] point_index
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast    // last_point
);
	import gopd_pkg::*;

	ctl_t        ctl_q, ctl_d;
	phase_t      phase_q, phase_d;
	logic [15:0] fc_q, fc_d, cc_q, cc_d, lep_q, lep_d, sk_q, sk_d;
	logic [7:0]  hold_q, hold_d, rep_q, rep_d, flag_q, flag_d, cur_q, cur_d;
	logic [6:0]  pc_q, pc_d, ec_q, ec_d, np;
	logic [15:0] xs_q, xs_d, ys_q, ys_d, xh_q, xh_d;
	status_t     err_q, err_d;
	logic        mv_q, mv_d, out_free, load;
	logic [15:0] ox_d, oy_d;
	logic [5:0]  oi_d;
	logic        ol_d;
	status_t     os_d;
	logic [15:0] ox_q, oy_q;
	logic [5:0]  oi_q;
	logic        ol_q;
	status_t     os_q;

	logic             fw_we, xw_we;
	logic [PT_AW-1:0] fw_addr, xw_addr, fr_addr;
	logic [7:0]       fw_data, flag_rd;
	logic [15:0]      xw_data, x_rd;

	gopd_ram #(.WIDTH(8), .DEPTH(MAX_POINTS)) u_flag_ram (
		.clk(clk), .we(fw_we), .waddr(fw_addr), .wdata(fw_data),
		.raddr(fr_addr), .rdata(flag_rd)
	);

	gopd_ram #(.WIDTH(16), .DEPTH(MAX_POINTS)) u_x_ram (
		.clk(clk), .we(xw_we), .waddr(xw_addr), .wdata(xw_data),
		.raddr(ec_q[PT_AW-1:0]), .rdata(x_rd)
	);

	assign np       = {1'b0, lep_q[PT_AW-1:0]} + 7'd1;
	assign out_free = !mv_q || m_tready;
	assign fr_addr  = (ctl_q == C_YRD) ? ec_q[PT_AW-1:0] : pc_q[PT_AW-1:0];

	// sequencer: next state, store writes, result load
	always_comb begin
		ctl_d = ctl_q; phase_d = phase_q; fc_d = fc_q; cc_d = cc_q; lep_d = lep_q;
		sk_d = sk_q; hold_d = hold_q; rep_d = rep_q; flag_d = flag_q; cur_d = cur_q;
		pc_d = pc_q; ec_d = ec_q; xs_d = xs_q; ys_d = ys_q; xh_d = xh_q; err_d = err_q;
		s_tready = 1'b0;
		fw_we = 1'b0; fw_addr = pc_q[PT_AW-1:0]; fw_data = flag_q;
		xw_we = 1'b0; xw_addr = pc_q[PT_AW-1:0]; xw_data = xs_q;
		load = 1'b0; ox_d = '0; oy_d = '0; oi_d = '0; ol_d = 1'b1; os_d = ST_OK;
		case (ctl_q)
			C_IN: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_tuser) begin
						hold_d = s_tdata; fc_d = '0; cc_d = '0; lep_d = '0; sk_d = '0;
						rep_d = '0; pc_d = '0; ec_d = '0; xs_d = '0; ys_d = '0;
						phase_d = PH_NC_LO;
					end else begin
						case (phase_q)
							PH_NC_LO: begin
								cc_d = {hold_q, s_tdata};
								if (hold_q[7]) begin
									err_d = ST_COMPOSITE; ctl_d = C_ERR; phase_d = PH_DONE;
								end else begin
									fc_d = BBOX_BYTES; phase_d = PH_BBOX;
								end
							end
							PH_BBOX: begin
								fc_d = fc_q - 16'd1;
								if (fc_q == 16'd1) begin
									if (cc_q == '0) begin
										phase_d = PH_ILEN_HI;
									end else begin
										fc_d = {cc_q[14:0], 1'b0}; phase_d = PH_ENDPTS;
									end
								end
							end
							PH_ENDPTS: begin
								if (!fc_q[0]) hold_d = s_tdata;
								else lep_d = {hold_q, s_tdata};
								fc_d = fc_q - 16'd1;
								if (fc_q == 16'd1) begin
									if (lep_d >= 16'(MAX_POINTS)) begin
										err_d = ST_TOO_MANY; ctl_d = C_ERR; phase_d = PH_DONE;
									end else begin
										phase_d = PH_ILEN_HI;
									end
								end
							end
							PH_ILEN_HI: begin
								hold_d = s_tdata; phase_d = PH_ILEN_LO;
							end
							PH_ILEN_LO, PH_INSTR: begin
								sk_d = (phase_q == PH_INSTR) ? sk_q - 16'd1 : {hold_q, s_tdata};
								if (sk_d == '0) begin
									if (cc_q == '0) begin
										phase_d = PH_DONE;
									end else begin
										pc_d = '0; phase_d = PH_FLAG;
									end
								end else begin
									phase_d = PH_INSTR;
								end
							end
							PH_FLAG: begin
								fw_we = 1'b1; fw_data = s_tdata; flag_d = s_tdata;
								pc_d = pc_q + 7'd1;
								if (s_tdata[FLAG_REPEAT]) begin
									phase_d = PH_REPEAT;
								end else if (pc_d >= np) begin
									pc_d = '0; ctl_d = C_XRD;
								end
							end
							PH_REPEAT: begin
								rep_d = s_tdata; ctl_d = C_RPT;
							end
							PH_XB, PH_XL: begin
								if (phase_q == PH_XB && !cur_q[FLAG_X_SHORT]) begin
									hold_d = s_tdata; phase_d = PH_XL;
								end else begin
									if (phase_q == PH_XL) xs_d = xs_q + {hold_q, s_tdata};
									else if (cur_q[FLAG_X_SAME]) xs_d = xs_q + {8'd0, s_tdata};
									else xs_d = xs_q - {8'd0, s_tdata};
									xw_we = 1'b1; xw_data = xs_d;
									pc_d = pc_q + 7'd1; ctl_d = C_XRD;
								end
							end
							PH_YB, PH_YL: begin
								if (phase_q == PH_YB && !cur_q[FLAG_Y_SHORT]) begin
									hold_d = s_tdata; phase_d = PH_YL;
								end else begin
									if (phase_q == PH_YL) ys_d = ys_q + {hold_q, s_tdata};
									else if (cur_q[FLAG_Y_SAME]) ys_d = ys_q + {8'd0, s_tdata};
									else ys_d = ys_q - {8'd0, s_tdata};
									ctl_d = C_PEMIT;
								end
							end
							default: ;
						endcase
					end
				end
			end
			// copy the repeated flag, one point a cycle
			C_RPT: begin
				if (rep_q != '0 && pc_q < np) begin
					fw_we = 1'b1; pc_d = pc_q + 7'd1; rep_d = rep_q - 8'd1;
				end else begin
					rep_d = '0;
					if (pc_q >= np) begin
						pc_d = '0; ctl_d = C_XRD;
					end else begin
						phase_d = PH_FLAG; ctl_d = C_IN;
					end
				end
			end
			C_XRD: begin
				if (pc_q >= np) begin
					ec_d = '0; ctl_d = C_YRD;
				end else begin
					ctl_d = C_XEV;
				end
			end
			// points with no x bytes repeat the running x
			C_XEV: begin
				if (!flag_rd[FLAG_X_SHORT] && flag_rd[FLAG_X_SAME]) begin
					xw_we = 1'b1; pc_d = pc_q + 7'd1; ctl_d = C_XRD;
				end else begin
					cur_d = flag_rd; phase_d = PH_XB; ctl_d = C_IN;
				end
			end
			C_YRD: begin
				if (ec_q >= np) begin
					phase_d = PH_DONE; ctl_d = C_IN;
				end else begin
					ctl_d = C_YEV;
				end
			end
			C_YEV: begin
				xh_d = x_rd;
				if (!flag_rd[FLAG_Y_SHORT] && flag_rd[FLAG_Y_SAME]) begin
					ctl_d = C_PEMIT;
				end else begin
					cur_d = flag_rd; phase_d = PH_YB; ctl_d = C_IN;
				end
			end
			C_PEMIT: begin
				if (out_free) begin
					load = 1'b1; ox_d = xh_q; oy_d = ys_q; oi_d = ec_q[PT_AW-1:0];
					ol_d = (ec_q + 7'd1 == np);
					ec_d = ec_q + 7'd1; ctl_d = C_YRD;
				end
			end
			C_ERR: begin
				if (out_free) begin
					load = 1'b1; os_d = err_q; ctl_d = C_IN;
				end
			end
			default: ctl_d = C_IN;
		endcase
		mv_d = load ? 1'b1 : (m_tready ? 1'b0 : mv_q);
	end

	// control and running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= C_IN; phase_q <= PH_IDLE; fc_q <= '0; cc_q <= '0; lep_q <= '0;
			sk_q <= '0; hold_q <= '0; rep_q <= '0; flag_q <= '0; cur_q <= '0;
			pc_q <= '0; ec_q <= '0; xs_q <= '0; ys_q <= '0; xh_q <= '0;
			err_q <= ST_OK; mv_q <= 1'b0;
		end else begin
			ctl_q <= ctl_d; phase_q <= phase_d; fc_q <= fc_d; cc_q <= cc_d; lep_q <= lep_d;
			sk_q <= sk_d; hold_q <= hold_d; rep_q <= rep_d; flag_q <= flag_d; cur_q <= cur_d;
			pc_q <= pc_d; ec_q <= ec_d; xs_q <= xs_d; ys_q <= ys_d; xh_q <= xh_d;
			err_q <= err_d; mv_q <= mv_d;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			ox_q <= ox_d; oy_q <= oy_d; oi_q <= oi_d; ol_q <= ol_d; os_q <= os_d;
		end
	end

	assign m_tvalid = mv_q;
	assign m_tdata  = {2'b00, oi_q, oy_q, ox_q};
	assign m_tuser  = os_q;
	assign m_tlast  = ol_q;

`ifndef SYNTHESIS
	a_xev_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q == C_XEV |-> $past(ctl_q) == C_XRD)
		else $error("x lookup evaluated without a flag read");
	a_pc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= 7'(MAX_POINTS))
		else $error("point counter past store depth");
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tlast && m_tdata == '0)
		else $error("error result malformed");
	a_no_input_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q == C_PEMIT |-> !s_tready)
		else $error("input taken while a point is pending");
`endif
endmodule

/* tb/sv/glyph_outline_point_decoder_unit_test.sv */
// Testbench for glyph_outline_point_decoder_unit: drives glyph records as byte streams
// and checks each point transfer against a behavioral decoder kept in the bench.
// Depends on gopd_pkg and the glyph_outline_point_decoder_unit RTL.
module glyph_outline_point_decoder_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import gopd_pkg::*;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [5:0]  idx;
		logic        last;
		status_t     st;
	} point_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	glyph_outline_point_decoder_unit uut (.*);

	always #4 clk = ~clk;

	// decoder state shadowed by the bench
	phase_t      ph = PH_IDLE;
	logic [15:0] fcnt, ncont, last_ep, skip;
	logic [7:0]  hold;
	logic [7:0]  flags [MAX_POINTS];
	logic [15:0] xs [MAX_POINTS];
	int          pcnt, ecnt;
	logic [15:0] xsum, ysum;

	point_t expected_points[$];
	int     errors = 0;
	int     send_idle = 0, recv_stall = 0;
	int     quiet = 0;
	int     n_items = 0;

	task automatic report_mismatch(input string msg);
		$display("ERROR %0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic int npts();
		return int'(last_ep) + 1;
	endfunction

	function automatic void push_point(input logic [15:0] x, input logic [15:0] y,
			input int idx, input logic last, input status_t st);
		point_t p;
		p.x = x; p.y = y; p.idx = idx[5:0]; p.last = last; p.st = st;
		expected_points.push_back(p);
	endfunction

	function automatic void emit_one();
		push_point(xs[ecnt % 64], ysum, ecnt, (ecnt + 1 == npts()), ST_OK);
		ecnt++;
	endfunction

	function automatic void walk_y();
		while (ecnt < npts() && !flags[ecnt][FLAG_Y_SHORT] && flags[ecnt][FLAG_Y_SAME])
			emit_one();
		ph = (ecnt >= npts()) ? PH_DONE : PH_YB;
	endfunction

	function automatic void walk_x();
		while (pcnt < npts() && !flags[pcnt][FLAG_X_SHORT] && flags[pcnt][FLAG_X_SAME]) begin
			xs[pcnt] = xsum;
			pcnt++;
		end
		if (pcnt >= npts()) begin
			ecnt = 0;
			walk_y();
		end else
			ph = PH_XB;
	endfunction

	function automatic void instr_done();
		if (ncont == 0) ph = PH_DONE;
		else begin
			pcnt = 0;
			ph = PH_FLAG;
		end
	endfunction

	// advance the shadow decoder by one accepted byte
	function automatic void decode_byte(input logic [7:0] b, input logic first);
		logic [7:0] f;
		if (first) begin
			hold = b; fcnt = 0; ncont = 0; last_ep = 0; skip = 0;
			pcnt = 0; ecnt = 0; xsum = 0; ysum = 0;
			ph = PH_NC_LO;
			return;
		end
		case (ph)
			PH_NC_LO: begin
				ncont = {hold, b};
				if (ncont[15]) begin
					push_point(0, 0, 0, 1'b1, ST_COMPOSITE);
					ph = PH_DONE;
				end else begin
					fcnt = BBOX_BYTES;
					ph = PH_BBOX;
				end
			end
			PH_BBOX: begin
				fcnt--;
				if (fcnt == 0) begin
					if (ncont == 0) ph = PH_ILEN_HI;
					else begin
						fcnt = 16'(2 * ncont);
						ph = PH_ENDPTS;
					end
				end
			end
			PH_ENDPTS: begin
				if (!fcnt[0]) hold = b;
				else last_ep = {hold, b};
				fcnt--;
				if (fcnt == 0) begin
					if (last_ep >= MAX_POINTS) begin
						push_point(0, 0, 0, 1'b1, ST_TOO_MANY);
						ph = PH_DONE;
					end else
						ph = PH_ILEN_HI;
				end
			end
			PH_ILEN_HI: begin
				hold = b;
				ph = PH_ILEN_LO;
			end
			PH_ILEN_LO: begin
				skip = {hold, b};
				if (skip == 0) instr_done();
				else ph = PH_INSTR;
			end
			PH_INSTR: begin
				skip--;
				if (skip == 0) instr_done();
			end
			PH_FLAG: begin
				flags[pcnt] = b;
				pcnt++;
				if (b[FLAG_REPEAT]) ph = PH_REPEAT;
				else if (pcnt >= npts()) begin
					pcnt = 0;
					walk_x();
				end
			end
			PH_REPEAT: begin
				f = flags[pcnt - 1];
				for (int r = b; r != 0 && pcnt < npts(); r--) begin
					flags[pcnt] = f;
					pcnt++;
				end
				if (pcnt >= npts()) begin
					pcnt = 0;
					walk_x();
				end else
					ph = PH_FLAG;
			end
			PH_XB: begin
				f = flags[pcnt];
				if (f[FLAG_X_SHORT]) begin
					xsum = f[FLAG_X_SAME] ? xsum + b : xsum - b;
					xs[pcnt] = xsum;
					pcnt++;
					walk_x();
				end else begin
					hold = b;
					ph = PH_XL;
				end
			end
			PH_XL: begin
				xsum = xsum + {hold, b};
				xs[pcnt] = xsum;
				pcnt++;
				walk_x();
			end
			PH_YB: begin
				f = flags[ecnt];
				if (f[FLAG_Y_SHORT]) begin
					ysum = f[FLAG_Y_SAME] ? ysum + b : ysum - b;
					emit_one();
					walk_y();
				end else begin
					hold = b;
					ph = PH_YL;
				end
			end
			PH_YL: begin
				ysum = ysum + {hold, b};
				emit_one();
				walk_y();
			end
			default: ;
		endcase
	endfunction

	// one byte transfer, with optional random idle before it;
	// tvalid stays up after the transfer until the next byte or idle
	task automatic send_byte(input logic [7:0] b, input logic first);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= first;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		decode_byte(b, first);
		n_items++;
		@(negedge clk);
	endtask

	task automatic send_word(input logic [15:0] w);
		send_byte(w[15:8], 1'b0);
		send_byte(w[7:0], 1'b0);
	endtask

	// receiver: random stall at each falling edge
	always @(negedge clk)
		m_tready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			point_t p;
			if (expected_points.size() == 0)
				report_mismatch($sformatf("unexpected point %h", m_tdata));
			else begin
				p = expected_points.pop_front();
				if (m_tdata[15:0] !== p.x)
					report_mismatch($sformatf("x %h, want %h", m_tdata[15:0], p.x));
				if (m_tdata[31:16] !== p.y)
					report_mismatch($sformatf("y %h, want %h", m_tdata[31:16], p.y));
				if (m_tdata[37:32] !== p.idx)
					report_mismatch($sformatf("index %0d, want %0d", m_tdata[37:32], p.idx));
				if (m_tlast !== p.last)
					report_mismatch($sformatf("last %b, want %b", m_tlast, p.last));
				if (m_tuser !== p.st)
					report_mismatch($sformatf("status %0d, want %0d", m_tuser, p.st));
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > 20000) begin
			$display("FAIL glyph_outline_point_decoder_unit");
			$finish;
		end
	end

	// build one well-formed simple glyph with random content
	task automatic send_glyph(input int n, input int ncnt, input int ilen, input bit rnd_flags,
			input logic [7:0] fixed_flag);
		logic [7:0] fl [MAX_POINTS];
		int i, r;
		send_byte(8'(ncnt >> 8), 1'b1);
		send_byte(8'(ncnt), 1'b0);
		repeat (8) send_byte(8'($urandom), 1'b0);
		for (i = 0; i < ncnt; i++)
			send_word((i == ncnt - 1) ? 16'(n - 1) : 16'($urandom));
		send_word(16'(ilen));
		repeat (ilen) send_byte(8'($urandom), 1'b0);
		if (ncnt == 0) return;
		i = 0;
		while (i < n) begin
			fl[i] = rnd_flags ? (8'($urandom) & 8'h37) : fixed_flag;
			if (rnd_flags && $urandom_range(3) == 0 && i + 1 < n) begin
				r = $urandom_range(n - i);
				send_byte(fl[i] | 8'h08 | (8'($urandom) & 8'hC0), 1'b0);
				send_byte(8'(r), 1'b0);
				for (int k = 1; k <= r && i + k < n; k++) fl[i + k] = fl[i];
				i += r + 1;
			end else begin
				send_byte(fl[i] | (8'($urandom) & 8'hC0), 1'b0);
				i++;
			end
		end
		for (i = 0; i < n; i++)
			if (fl[i][FLAG_X_SHORT]) send_byte(8'($urandom), 1'b0);
			else if (!fl[i][FLAG_X_SAME]) send_word(16'($urandom));
		for (i = 0; i < n; i++)
			if (fl[i][FLAG_Y_SHORT]) send_byte(8'($urandom), 1'b0);
			else if (!fl[i][FLAG_Y_SAME]) send_word(16'($urandom));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_points.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic test_directed();
		send_byte(8'hAA, 1'b0);                 // stray byte while idle
		send_glyph(1, 1, 0, 0, 8'h00);          // single point, word deltas
		send_glyph(4, 2, 2, 0, 8'h30);          // all zero-byte points: one burst
		send_glyph(3, 1, 0, 0, 8'h06);          // negative short deltas
		send_glyph(0, 0, 3, 0, 8'h00);          // zero contours, no result
		send_byte(8'hFF, 1'b1);                 // composite
		send_byte(8'hFF, 1'b0);
		send_byte(8'h12, 1'b0);                 // ignored tail
		send_byte(8'h00, 1'b1);                 // too many points
		send_byte(8'h01, 1'b0);
		repeat (8) send_byte(8'hFF, 1'b0);
		send_word(16'hFFFF);
		send_glyph(MAX_POINTS, 1, 0, 1, 8'h00); // largest glyph
		drain();
	endtask

	task automatic test_random(input int sidle, input int rstall, input int bytes);
		int start;
		send_idle = sidle;
		recv_stall = rstall;
		start = n_items;
		while (n_items - start < bytes) begin
			case ($urandom_range(9))
				0: begin
					send_byte(8'($urandom_range(128, 255)), 1'b1);
					repeat ($urandom_range(3)) send_byte(8'($urandom), 1'b0);
				end
				1: send_byte(8'($urandom), 1'(($urandom_range(3) == 0))); // noise
				default:
					send_glyph(($urandom_range(4) == 0) ? $urandom_range(1, 64) :
						$urandom_range(1, 8), $urandom_range(1, 3), $urandom_range(0, 3),
						1, 8'h00);
			endcase
		end
		drain();
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(0, 0, 30);
		test_random(69, 0, 30);
		test_random(0, 69, 30);
		test_random(10, 10, 30);
		if (errors == 0 && expected_points.size() == 0)
			$display("PASS glyph_outline_point_decoder_unit");
		else
			$display("FAIL glyph_outline_point_decoder_unit");
		$finish;
	end
endmodule
